@@ design/tccw_pkg.sv @@
// Shared types and constants for the text console cell writer.
package tccw_pkg;

  localparam int DEF_MAX_COLS = 128;
  localparam int DEF_MAX_ROWS = 32;

  // operation codes
  localparam logic [2:0] OP_PUT  = 3'd0;
  localparam logic [2:0] OP_MOVE = 3'd1;
  localparam logic [2:0] OP_SHOW = 3'd2;
  localparam logic [2:0] OP_HIDE = 3'd3;
  localparam logic [2:0] OP_READ = 3'd4;

  // control characters and cursor glyph
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_RETURN    = 8'h0d;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CURSOR_GLYPH = 8'h5f;
  localparam logic [7:0] CURSOR_ATTR  = 8'h8f;

  // configuration register indexes and reset values
  localparam logic [1:0] CFG_COLS  = 2'd0;
  localparam logic [1:0] CFG_ROWS  = 2'd1;
  localparam logic [1:0] CFG_COLOR = 2'd2;

  localparam logic [7:0] COLS_RST  = 8'd80;
  localparam logic [5:0] ROWS_RST  = 6'd25;
  localparam logic [7:0] COLOR_RST = 8'd7;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
    logic [6:0] target_col;
    logic [4:0] target_row;
  } tccw_in_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_color;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
  } tccw_out_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;  // capture the input item
    logic init;   // post-reset clearing pass
    logic exec;   // apply the op to cursor and store
    logic copy;   // scroll: move rows up
    logic clr;    // scroll: clear the bottom row
    logic rd;     // read the result cell
  } tccw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic init_last;
    logic scroll_need;
    logic copy_last;
    logic clr_last;
  } tccw_sts_t;

endpackage

@@ design/tccw_ram.sv @@
// Generic simple dual-port RAM with registered read.
module tccw_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/tccw_ctrl.sv @@
// Sequencer for the text console cell writer.
module tccw_ctrl import tccw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  tccw_sts_t sts,
  output tccw_cmd_t cmd,
  output logic      busy,
  output logic      out_valid
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_COPY,
    S_CLR,
    S_READ,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, out_valid_r;
  logic   take;

  assign take = start && (state_r == S_IDLE || state_r == S_RESP);

  always_comb begin
    cmd       = '0;
    cmd.latch = take;
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        cmd.init = 1'b1;
        if (sts.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.scroll_need ? S_COPY : S_READ;
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (sts.copy_last) begin
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        state_nxt = take ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= !(state_nxt == S_IDLE || state_nxt == S_RESP);
      out_valid_r <= (state_nxt == S_RESP);
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

@@ design/tccw_dp.sv @@
// Datapath: config registers, cursor, screen store and scroll/clear sweep.
module tccw_dp import tccw_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  tccw_in_t   in_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [7:0] cfg_wdata,
  input  tccw_cmd_t  cmd,
  output tccw_sts_t  sts,
  output tccw_out_t  out_item
);

  localparam int Total = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(Total);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int RCW   = $clog2(MAX_ROWS + 1);

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c,
                                               input logic [RW-1:0] r);
    return AW'(r * MAX_COLS + c);
  endfunction

  // config
  logic [7:0] cols_r, color_r;
  logic [5:0] rows_r;

  // item and cursor
  tccw_in_t        item_r;
  logic [CW-1:0]   cur_col_r, res_col_r;
  logic [RW-1:0]   cur_row_r, res_row_r;
  logic [AW-1:0]   cnt_r;

  logic [CCW-1:0]  cols_eff, ccol, ncol, rcol;
  logic [RCW-1:0]  rows_eff, crow, nrow, rrow;
  logic            scroll;
  logic            ex_we;
  logic [15:0]     ex_wdata;
  logic [AW:0]     copy_end, clr_end;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [15:0]     ram_wdata, ram_rdata;

  always_comb begin
    if (cols_r == 8'd0) begin
      cols_eff = CCW'(1);
    end else if (int'(cols_r) > MAX_COLS) begin
      cols_eff = CCW'(MAX_COLS);
    end else begin
      cols_eff = CCW'(cols_r);
    end
    if (rows_r == 6'd0) begin
      rows_eff = RCW'(1);
    end else if (int'(rows_r) > MAX_ROWS) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(rows_r);
    end
  end

  // cursor is pulled back inside the screen if the screen shrank
  assign ccol = (CCW'(cur_col_r) >= cols_eff) ? cols_eff - 1'b1 : CCW'(cur_col_r);
  assign crow = (RCW'(cur_row_r) >= rows_eff) ? rows_eff - 1'b1 : RCW'(cur_row_r);

  always_comb begin
    ncol     = ccol;
    nrow     = crow;
    rcol     = ccol;
    rrow     = crow;
    scroll   = 1'b0;
    ex_we    = 1'b0;
    ex_wdata = '0;
    case (item_r.op)
      OP_PUT: begin
        if (item_r.ch == CH_NEWLINE) begin
          nrow = crow + 1'b1;
          ncol = '0;
        end else if (item_r.ch == CH_RETURN) begin
          ncol = '0;
        end else if (item_r.ch == CH_BACKSPACE) begin
          ex_we = 1'b1;
          if (ccol != '0) begin
            ncol = ccol - 1'b1;
          end else if (crow != '0) begin
            nrow = crow - 1'b1;
            ncol = cols_eff - 1'b1;
          end
        end else begin
          ex_we    = 1'b1;
          ex_wdata = {color_r, item_r.ch};
          ncol     = ccol + 1'b1;
        end
        if (ncol >= cols_eff) begin
          ncol = '0;
          nrow = nrow + 1'b1;
        end
        if (nrow >= rows_eff) begin
          scroll = 1'b1;
          nrow   = rows_eff - 1'b1;
        end
        rcol = ncol;
        rrow = nrow;
      end
      OP_MOVE: begin
        ncol = (item_r.target_col < cols_eff) ? CCW'(item_r.target_col) : cols_eff - 1'b1;
        nrow = (item_r.target_row < rows_eff) ? RCW'(item_r.target_row) : rows_eff - 1'b1;
        rcol = ncol;
        rrow = nrow;
      end
      OP_SHOW: begin
        ex_we    = 1'b1;
        ex_wdata = {CURSOR_ATTR, CURSOR_GLYPH};
      end
      OP_HIDE: begin
        ex_we = 1'b1;
      end
      OP_READ: begin
        rcol = (item_r.target_col < cols_eff) ? CCW'(item_r.target_col) : cols_eff - 1'b1;
        rrow = (item_r.target_row < rows_eff) ? RCW'(item_r.target_row) : rows_eff - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // scroll moves whole store rows, then clears the bottom in-use row
  assign copy_end = (AW+1)'((rows_eff - 1'b1) * MAX_COLS);
  assign clr_end  = (AW+1)'(rows_eff * MAX_COLS - 1);

  assign sts.init_last   = (cnt_r == AW'(Total - 1));
  assign sts.scroll_need = scroll;
  assign sts.copy_last   = ({1'b0, cnt_r} == copy_end);
  assign sts.clr_last    = ({1'b0, cnt_r} == clr_end);

  // store write port: copy writes each word that the registered read returned, one store row lower
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = '0;
    if (cmd.exec) begin
      ram_we    = ex_we;
      ram_waddr = cell_addr(CW'(ccol), RW'(crow));
      ram_wdata = ex_wdata;
    end else if (cmd.copy) begin
      ram_we    = (cnt_r != '0);
      ram_waddr = cnt_r - 1'b1;
      ram_wdata = ram_rdata;
    end else if (cmd.clr || cmd.init) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = cmd.rd ? cell_addr(res_col_r, res_row_r) : cnt_r + AW'(MAX_COLS);

  tccw_ram #(
    .Width(16),
    .Depth(Total)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r    <= COLS_RST;
      rows_r    <= ROWS_RST;
      color_r   <= COLOR_RST;
      cur_col_r <= '0;
      cur_row_r <= '0;
      cnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_COLS:  cols_r  <= cfg_wdata;
          CFG_ROWS:  rows_r  <= cfg_wdata[5:0];
          CFG_COLOR: color_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (cmd.exec) begin
        cur_col_r <= CW'(ncol);
        cur_row_r <= RW'(nrow);
        cnt_r     <= '0;
      end else if (cmd.copy) begin
        cnt_r <= sts.copy_last ? cnt_r : cnt_r + 1'b1;
      end else if (cmd.clr || cmd.init) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_item;
    end
    if (cmd.exec) begin
      res_col_r <= CW'(rcol);
      res_row_r <= RW'(rrow);
    end
  end

  assign out_item.cell_char  = ram_rdata[7:0];
  assign out_item.cell_color = ram_rdata[15:8];
  assign out_item.cursor_col = 7'(cur_col_r);
  assign out_item.cursor_row = 5'(cur_row_r);

endmodule

@@ design/text_console_cell_writer_core.sv @@
// Text console cell writer: top level joining sequencer and datapath.
// After start is taken the sequencer steps through EXEC and READ, and the result strobe rises in RESP;
// a new start is taken in the result cycle.
// A scroll adds a copy sweep that moves the rows up and then a sweep that clears the bottom row,
// one store word per cycle through the single write port.
// After reset, busy stays high while the store is zeroed.
// The receiver cannot stall; each result is shown for one cycle only.
module text_console_cell_writer_core import tccw_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  tccw_in_t   in_item,
  output logic       out_valid,
  output tccw_out_t  out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [7:0] cfg_wdata
);

  tccw_cmd_t cmd;
  tccw_sts_t sts;

  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .out_valid(out_valid)
  );

  tccw_dp #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

@@ test/tb_text_console_cell_writer_core.sv @@
// Testbench for text_console_cell_writer_core: directed and random console ops against a predictor.
module tb_text_console_cell_writer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tccw_pkg::*;

  localparam int STORE_CELLS = DEF_MAX_COLS * DEF_MAX_ROWS;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_OPS   = 62;
  localparam int NUM_PHASES  = 6;
  // op codes the block does not define
  localparam logic [2:0] OP_BAD_LO = 3'd5;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  tccw_in_t   in_item = '0;
  logic       out_valid;
  tccw_out_t  out_item;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_idx = CFG_COLS;
  logic [7:0] cfg_wdata = '0;

  text_console_cell_writer_core #(
    .MAX_COLS(DEF_MAX_COLS),
    .MAX_ROWS(DEF_MAX_ROWS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predicted console state
  logic [15:0] screen_img [STORE_CELLS];
  int unsigned crs_col, crs_row;
  logic [7:0]  cols_reg = COLS_RST;
  logic [5:0]  rows_reg = ROWS_RST;
  logic [7:0]  color_reg = COLOR_RST;

  tccw_in_t  pending_ops[$];
  tccw_out_t expected_cells[$];

  int err_cnt = 0;
  int ops_sent = 0;
  int results_checked = 0;
  int scroll_cnt = 0;
  int settings_cnt = 1;
  int gap_left = 0;
  int stall_cycles = 0;
  bit steady = 1'b0;

  function automatic int unsigned eff_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > DEF_MAX_COLS) return DEF_MAX_COLS;
    return 32'(cols_reg);
  endfunction

  function automatic int unsigned eff_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
    return 32'(rows_reg);
  endfunction

  function automatic int unsigned cell_addr(int unsigned c, int unsigned r);
    return (r * DEF_MAX_COLS + c) % STORE_CELLS;
  endfunction

  function automatic tccw_out_t console_apply(tccw_in_t it);
    int unsigned ncols, nrows, rc, rr;
    logic [15:0] cell_word;
    tccw_out_t res;
    ncols = eff_cols();
    nrows = eff_rows();
    // screen may have shrunk under the cursor
    if (crs_col >= ncols) crs_col = ncols - 1;
    if (crs_row >= nrows) crs_row = nrows - 1;
    rc = crs_col;
    rr = crs_row;
    case (it.op)
      OP_PUT: begin
        if (it.ch == CH_NEWLINE) begin
          crs_row++;
          crs_col = 0;
        end else if (it.ch == CH_RETURN) begin
          crs_col = 0;
        end else if (it.ch == CH_BACKSPACE) begin
          screen_img[cell_addr(crs_col, crs_row)] = '0;
          if (crs_col > 0) begin
            crs_col--;
          end else if (crs_row > 0) begin
            crs_row--;
            crs_col = ncols - 1;
          end
        end else begin
          screen_img[cell_addr(crs_col, crs_row)] = {color_reg, it.ch};
          crs_col++;
        end
        if (crs_col >= ncols) begin
          crs_col = 0;
          crs_row++;
        end
        if (crs_row >= nrows) begin
          // full store rows move, hidden columns too
          for (int i = 0; i < (nrows - 1) * DEF_MAX_COLS; i++)
            screen_img[i] = screen_img[i + DEF_MAX_COLS];
          for (int i = 0; i < DEF_MAX_COLS; i++)
            screen_img[(nrows - 1) * DEF_MAX_COLS + i] = '0;
          crs_row = nrows - 1;
          scroll_cnt++;
        end
        rc = crs_col;
        rr = crs_row;
      end
      OP_MOVE: begin
        crs_col = (it.target_col < ncols) ? 32'(it.target_col) : ncols - 1;
        crs_row = (it.target_row < nrows) ? 32'(it.target_row) : nrows - 1;
        rc = crs_col;
        rr = crs_row;
      end
      OP_SHOW: screen_img[cell_addr(crs_col, crs_row)] = {CURSOR_ATTR, CURSOR_GLYPH};
      OP_HIDE: screen_img[cell_addr(crs_col, crs_row)] = '0;
      OP_READ: begin
        rc = (it.target_col < ncols) ? 32'(it.target_col) : ncols - 1;
        rr = (it.target_row < nrows) ? 32'(it.target_row) : nrows - 1;
      end
      default: ;
    endcase
    cell_word = screen_img[cell_addr(rc, rr)];
    res.cell_char  = cell_word[7:0];
    res.cell_color = cell_word[15:8];
    res.cursor_col = crs_col[6:0];
    res.cursor_row = crs_row[4:0];
    return res;
  endfunction

  function automatic tccw_in_t mk_op(logic [2:0] op, logic [7:0] ch, int c, int r);
    tccw_in_t it;
    it.op = op;
    it.ch = ch;
    it.target_col = c[6:0];
    it.target_row = r[4:0];
    return it;
  endfunction

  function automatic tccw_in_t rand_op();
    int w, k;
    int unsigned cmax, rmax;
    tccw_in_t it;
    w = $urandom_range(0, 99);
    k = $urandom_range(0, 9);
    cmax = (eff_cols() + 1 > 127) ? 127 : eff_cols() + 1;
    rmax = (eff_rows() + 1 > 31) ? 31 : eff_rows() + 1;
    it.ch = 8'($urandom_range(0, 255));
    // targets mostly near the in-use screen, sometimes anywhere
    it.target_col = 7'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                    : $urandom_range(0, cmax));
    it.target_row = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(0, rmax));
    if (w < 55) begin
      it.op = OP_PUT;
      if (k == 0) it.ch = CH_NEWLINE;
      else if (k == 1) it.ch = CH_RETURN;
      else if (k <= 3) it.ch = CH_BACKSPACE;
    end else if (w < 67) it.op = OP_MOVE;
    else if (w < 75) it.op = OP_SHOW;
    else if (w < 83) it.op = OP_HIDE;
    else if (w < 95) it.op = OP_READ;
    else it.op = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
    return it;
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_COLS:  cols_reg = val;
      CFG_ROWS:  rows_reg = val[5:0];
      CFG_COLOR: color_reg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_screen(logic [7:0] cols, logic [7:0] rows, logic [7:0] color);
    cfg_write(CFG_COLS, cols);
    cfg_write(CFG_ROWS, rows);
    cfg_write(CFG_COLOR, color);
    settings_cnt++;
  endtask

  // all transfers done, block quiet, then a short settle
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_ops.size() != 0 || expected_cells.size() != 0 || start || busy);
    repeat (6) @(posedge clk);
  endtask

  // driver: start held with the item until the block takes it
  always @(posedge clk) begin : drive_ops
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_cells.push_back(console_apply(pending_ops.pop_front()));
        ops_sent++;
        gap_left = steady ? 0 : $urandom_range(0, 6);
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          start   <= 1'b1;
          in_item <= pending_ops[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobe is one result transfer
  always @(posedge clk) begin : check_cells
    tccw_out_t want;
    if (rst_n && out_valid) begin
      if (expected_cells.size() == 0) begin
        $error("result with nothing pending: %p", out_item);
        err_cnt++;
      end else begin
        want = expected_cells.pop_front();
        results_checked++;
        if (out_item.cell_char !== want.cell_char) begin
          $error("cell_char: expected %0h, got %0h", want.cell_char, out_item.cell_char);
          err_cnt++;
        end
        if (out_item.cell_color !== want.cell_color) begin
          $error("cell_color: expected %0h, got %0h", want.cell_color, out_item.cell_color);
          err_cnt++;
        end
        if (out_item.cursor_col !== want.cursor_col) begin
          $error("cursor_col: expected %0d, got %0d", want.cursor_col, out_item.cursor_col);
          err_cnt++;
        end
        if (out_item.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, out_item.cursor_row);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[text_console_cell_writer_core] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [7:0] cols, rows;
    for (int i = 0; i < STORE_CELLS; i++) screen_img[i] = '0;
    crs_col = 0;
    crs_row = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // default 80x25: clamps, wrap into scroll, control chars, cursor glyph
    pending_ops.push_back(mk_op(OP_READ, 8'h00, 127, 31));
    pending_ops.push_back(mk_op(OP_MOVE, 8'hff, 127, 31));
    pending_ops.push_back(mk_op(OP_PUT, 8'h41, 0, 0));
    pending_ops.push_back(mk_op(OP_PUT, 8'hff, 0, 0));
    pending_ops.push_back(mk_op(OP_PUT, CH_BACKSPACE, 0, 0));
    pending_ops.push_back(mk_op(OP_PUT, CH_BACKSPACE, 0, 0));
    pending_ops.push_back(mk_op(OP_PUT, CH_NEWLINE, 0, 0));
    pending_ops.push_back(mk_op(OP_PUT, CH_NEWLINE, 0, 0));
    pending_ops.push_back(mk_op(OP_PUT, CH_RETURN, 0, 0));
    pending_ops.push_back(mk_op(OP_MOVE, 8'h00, 0, 0));
    pending_ops.push_back(mk_op(OP_PUT, CH_BACKSPACE, 0, 0));
    pending_ops.push_back(mk_op(OP_SHOW, 8'h00, 0, 0));
    pending_ops.push_back(mk_op(OP_READ, 8'h00, 0, 0));
    pending_ops.push_back(mk_op(OP_HIDE, 8'h00, 0, 0));
    pending_ops.push_back(mk_op(OP_BAD_LO, 8'h00, 3, 3));
    pending_ops.push_back(mk_op(OP_BAD_HI, 8'hff, 127, 31));
    wait_idle();

    // zero sizes act as a 1x1 screen
    set_screen(8'h00, 8'h00, 8'h00);
    pending_ops.push_back(mk_op(OP_PUT, 8'h00, 0, 0));
    pending_ops.push_back(mk_op(OP_PUT, CH_NEWLINE, 0, 0));
    pending_ops.push_back(mk_op(OP_PUT, CH_BACKSPACE, 0, 0));
    pending_ops.push_back(mk_op(OP_MOVE, 8'h00, 127, 31));
    pending_ops.push_back(mk_op(OP_READ, 8'h00, 127, 31));
    wait_idle();

    // oversize values clamp to the full store
    set_screen(8'hff, 8'hff, 8'hff);
    pending_ops.push_back(mk_op(OP_MOVE, 8'h00, 127, 31));
    pending_ops.push_back(mk_op(OP_PUT, 8'h41, 0, 0));
    pending_ops.push_back(mk_op(OP_SHOW, 8'h00, 0, 0));
    pending_ops.push_back(mk_op(OP_READ, 8'h00, 127, 31));
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case ($urandom_range(0, 7))
        0: cols = 8'd0;
        1: cols = 8'd128;
        2: cols = 8'($urandom_range(129, 255));
        3: cols = 8'd80;
        default: cols = 8'($urandom_range(1, 12));
      endcase
      if (p == 3) begin
        // one tall screen; scrolls there are long
        case ($urandom_range(0, 2))
          0: rows = 8'd25;
          1: rows = 8'd32;
          default: rows = 8'd63;
        endcase
      end else begin
        case ($urandom_range(0, 5))
          0: rows = 8'd0;
          1: rows = 8'd1;
          default: rows = 8'($urandom_range(2, 6));
        endcase
      end
      set_screen(cols, rows, 8'($urandom_range(0, 255)));
      steady = (p == 1 || p == 4);
      for (int n = 0; n < PHASE_OPS; n++) pending_ops.push_back(rand_op());
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("Ran %0d console ops over %0d screen settings with %0d scrolls.",
             ops_sent, settings_cnt, scroll_cnt);
    $display("Checked %0d result cells and cursor positions.", results_checked);
    if (err_cnt == 0) begin
      $display("[text_console_cell_writer_core] OK");
    end else begin
      $display("[text_console_cell_writer_core] ERROR");
    end
    $finish;
  end

endmodule
